// ----- sv/umr2d_pkg.sv -----
package umr2d_pkg;

  localparam int NODE_W = 12;
  localparam int KEY_W  = 2 * NODE_W;
  localparam int REF_W  = 16;

  // Input commands.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_QUAD = 2'd2;
  localparam logic [1:0] CMD_EDGE = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_POINT = 3'd0;
  localparam logic [2:0] KIND_TRI   = 3'd1;
  localparam logic [2:0] KIND_QUAD  = 3'd2;
  localparam logic [2:0] KIND_EDGE  = 3'd3;
  localparam logic [2:0] KIND_OVF   = 3'd4;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_c;
    logic [NODE_W-1:0] node_d;
    logic [REF_W-1:0]  region_ref;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [NODE_W-1:0]  point_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [NODE_W-1:0]  vert_a;
    logic [NODE_W-1:0]  vert_b;
    logic [NODE_W-1:0]  vert_c;
    logic [NODE_W-1:0]  vert_d;
    logic [REF_W-1:0]   child_ref;
    logic               last;
  } out_item_t;

endpackage

// ----- sv/umr2d_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module umr2d_ram #(
  parameter int W  = 64,
  parameter int D  = 4096,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [W-1:0]  wd,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [W-1:0]  rq
);

  logic [W-1:0] mem [D];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rq <= mem[ra];
    end
  end

endmodule

// ----- sv/uniform_mesh_refine_2d_core.sv -----
// Uniform 2D mesh refinement by edge midpoints. Load points first (cmd 0, no
// result unless the store is full: then an overflow result), then send
// triangles, quads or boundary edges. Each element item looks up its edges by
// scanning the edge table memory from entry 0 up to the current fill count,
// reading and then comparing each entry until the edge is found. An overflow
// check follows, then each new midpoint reads both endpoints and is written,
// a quad centroid reads its four corners and is written, and the child
// results follow. Results leave through one output register, and a result
// still waiting there holds the sequencer wherever it would load the next one.
// The edge table needs no clearing after reset: only entries below the fill
// count are ever read. Reading a point that was never loaded gives undefined
// coordinates; a node index at or beyond MAX_POINTS reads as the origin.
module uniform_mesh_refine_2d_core #(
  parameter int MAX_POINTS = 4096,
  parameter int EDGE_SLOTS = 4096,
  parameter int COORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  umr2d_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output umr2d_pkg::out_item_t out_data
);

  localparam int CW     = COORD_BITS;
  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int EIDX_W = $clog2(EDGE_SLOTS);
  localparam int PC_W   = PIDX_W + 1;
  localparam int EC_W   = EIDX_W + 1;
  localparam int XW     = ((PIDX_W > umr2d_pkg::NODE_W) ? PIDX_W : umr2d_pkg::NODE_W) + 1;
  localparam int NW     = umr2d_pkg::NODE_W;
  localparam int KW     = umr2d_pkg::KEY_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LK_RD, S_LK_CMP, S_CHECK, S_MP_NEXT, S_MP_RA, S_MP_RB, S_MP_WR,
    S_CEN_RA, S_CEN_ACC, S_CEN_WR, S_CHILD, S_OVF
  } state_t;

  state_t                    state_r;
  logic [1:0]                cmd_r;
  logic [NW-1:0]             nd_r [4];
  logic [umr2d_pkg::REF_W-1:0] ref_r;
  logic [PC_W-1:0]           pc_r;
  logic [EC_W-1:0]           ec_r;
  logic [EC_W-1:0]           scan_r;
  logic [1:0]                j_r;
  logic [2:0]                fresh_r;
  logic [KW-1:0]             key_r [4];
  logic [3:0]                new_r;
  logic [3:0]                dup_r;
  logic [1:0]                dupk_r [4];
  logic [PIDX_W-1:0]         mid_r [4];
  logic [PIDX_W-1:0]         cen_r;
  logic [1:0]                cen_i_r;
  logic [1:0]                k_r;
  logic                      zflag_r;
  logic signed [CW-1:0]      ax_r, ay_r;
  logic signed [CW-1:0]      hx_r, hy_r;
  logic [3:0]                lx_r, ly_r;
  logic                      out_valid_r;
  umr2d_pkg::out_item_t      out_data_r;

  // Memory ports.
  logic                  p_we, p_re, e_we, e_re;
  logic [PIDX_W-1:0]     p_wa, p_ra;
  logic [2*CW-1:0]       p_wd, p_q;
  logic [EIDX_W-1:0]     e_wa, e_ra;
  logic [KW+PIDX_W-1:0]  e_wd, e_q;

  umr2d_ram #(.W(2 * CW), .D(MAX_POINTS), .AW(PIDX_W)) u_points (
    .clk(clk), .we(p_we), .wa(p_wa), .wd(p_wd), .re(p_re), .ra(p_ra), .rq(p_q)
  );

  umr2d_ram #(.W(KW + PIDX_W), .D(EDGE_SLOTS), .AW(EIDX_W)) u_edges (
    .clk(clk), .we(e_we), .wa(e_wa), .wd(e_wd), .re(e_re), .ra(e_ra), .rq(e_q)
  );

  // Edge endpoints of the current edge and its unordered key.
  logic [1:0]    q_j, j_last;
  logic [NW-1:0] p_node, q_node, lo_node, hi_node;
  logic [KW-1:0] key_cur;

  always_comb begin
    unique case (cmd_r)
      umr2d_pkg::CMD_TRI:  begin q_j = (j_r == 2'd2) ? 2'd0 : j_r + 2'd1; j_last = 2'd2; end
      umr2d_pkg::CMD_QUAD: begin q_j = j_r + 2'd1;                        j_last = 2'd3; end
      default:             begin q_j = 2'd1;                              j_last = 2'd0; end
    endcase
    p_node  = nd_r[j_r];
    q_node  = nd_r[q_j];
    lo_node = (p_node < q_node) ? p_node : q_node;
    hi_node = (p_node < q_node) ? q_node : p_node;
    key_cur = {lo_node, hi_node};
  end

  // An edge not in the table may repeat an earlier new edge of this item.
  logic       dup_hit;
  logic [1:0] dup_k;

  always_comb begin
    dup_hit = 1'b0;
    dup_k   = 2'd0;
    for (int k = 2; k >= 0; k--) begin
      if (2'(k) < j_r && new_r[k] && key_r[k] == key_cur) begin
        dup_hit = 1'b1;
        dup_k   = 2'(k);
      end
    end
  end

  // Point reads: node selection and out-of-range detection.
  logic [NW-1:0] rd_node;
  logic [XW-1:0] rd_ext;
  logic          rd_oor;

  always_comb begin
    unique case (state_r)
      S_MP_RA:  rd_node = p_node;
      S_MP_RB:  rd_node = q_node;
      default:  rd_node = nd_r[cen_i_r];
    endcase
    rd_ext = XW'(rd_node);
    rd_oor = rd_ext >= XW'(MAX_POINTS);
    p_re   = (state_r == S_MP_RA) || (state_r == S_MP_RB) || (state_r == S_CEN_RA);
    p_ra   = rd_ext[PIDX_W-1:0];
  end

  logic signed [CW-1:0] cur_x, cur_y;
  assign cur_x = zflag_r ? '0 : p_q[2*CW-1:CW];
  assign cur_y = zflag_r ? '0 : p_q[CW-1:0];

  // Midpoint and centroid arithmetic; shifts round toward minus infinity.
  logic signed [CW-1:0] mx, my, cx, cy, ldx, ldy;
  assign mx  = (ax_r >>> 1) + (cur_x >>> 1) + $signed(CW'(ax_r[0] & cur_x[0]));
  assign my  = (ay_r >>> 1) + (cur_y >>> 1) + $signed(CW'(ay_r[0] & cur_y[0]));
  assign cx  = hx_r + CW'(lx_r[3:2]);
  assign cy  = hy_r + CW'(ly_r[3:2]);
  assign ldx = CW'(in_data.x_coord);
  assign ldy = CW'(in_data.y_coord);

  logic ostall, in_acc, out_load;
  assign ostall = out_valid_r && !out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;

  // A result enters the output register in these states once the register frees up.
  assign out_load = !ostall && ((state_r == S_MP_WR) || (state_r == S_CEN_WR) ||
                                (state_r == S_CHILD) || (state_r == S_OVF));

  // Point store writes, edge table reads and edge table writes.
  always_comb begin
    p_we = 1'b0;
    p_wa = pc_r[PIDX_W-1:0];
    p_wd = {mx, my};
    e_we = 1'b0;
    e_wa = ec_r[EIDX_W-1:0];
    e_wd = {key_cur, pc_r[PIDX_W-1:0]};
    e_re = (state_r == S_LK_RD) && (scan_r < ec_r);
    e_ra = scan_r[EIDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        p_we = in_acc && (in_data.cmd == umr2d_pkg::CMD_LOAD) && (pc_r != PC_W'(MAX_POINTS));
        p_wd = {ldx, ldy};
      end
      S_MP_WR: begin
        p_we = !ostall;
        e_we = !ostall;
      end
      S_CEN_WR: begin
        p_we = !ostall;
        p_wd = {cx, cy};
      end
      default: ;
    endcase
  end

  // Overflow check for the whole element.
  logic [2:0]    need;
  logic          ovf_elem;
  assign need     = fresh_r + ((cmd_r == umr2d_pkg::CMD_QUAD) ? 3'd1 : 3'd0);
  assign ovf_elem = ({1'b0, pc_r} + (PC_W + 1)'(need) > (PC_W + 1)'(MAX_POINTS)) ||
                    ({1'b0, ec_r} + (EC_W + 1)'(fresh_r) > (EC_W + 1)'(EDGE_SLOTS));

  // Child element table.
  logic [NW-1:0] m0, m1, m2, m3, cc;
  umr2d_pkg::out_item_t child;
  assign m0 = NW'(mid_r[0]);
  assign m1 = NW'(mid_r[1]);
  assign m2 = NW'(mid_r[2]);
  assign m3 = NW'(mid_r[3]);
  assign cc = NW'(cen_r);

  always_comb begin
    child           = '0;
    child.child_ref = ref_r;
    unique case (cmd_r)
      umr2d_pkg::CMD_TRI: begin
        child.kind = umr2d_pkg::KIND_TRI;
        child.last = (k_r == 2'd3);
        unique case (k_r)
          2'd0:    {child.vert_a, child.vert_b, child.vert_c} = {nd_r[0], m0, m2};
          2'd1:    {child.vert_a, child.vert_b, child.vert_c} = {m0, nd_r[1], m1};
          2'd2:    {child.vert_a, child.vert_b, child.vert_c} = {m2, m1, nd_r[2]};
          default: {child.vert_a, child.vert_b, child.vert_c} = {m0, m1, m2};
        endcase
      end
      umr2d_pkg::CMD_QUAD: begin
        child.kind = umr2d_pkg::KIND_QUAD;
        child.last = (k_r == 2'd3);
        unique case (k_r)
          2'd0:    {child.vert_a, child.vert_b, child.vert_c, child.vert_d} = {nd_r[0], m0, cc, m3};
          2'd1:    {child.vert_a, child.vert_b, child.vert_c, child.vert_d} = {m0, nd_r[1], m1, cc};
          2'd2:    {child.vert_a, child.vert_b, child.vert_c, child.vert_d} = {cc, m1, nd_r[2], m2};
          default: {child.vert_a, child.vert_b, child.vert_c, child.vert_d} = {m3, cc, m2, nd_r[3]};
        endcase
      end
      default: begin
        child.kind = umr2d_pkg::KIND_EDGE;
        child.last = (k_r == 2'd1);
        if (k_r == 2'd0) begin
          {child.vert_a, child.vert_b} = {nd_r[0], m0};
        end else begin
          {child.vert_a, child.vert_b} = {m0, nd_r[1]};
        end
      end
    endcase
  end

  // Sequencer: state, counters and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      ec_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (p_re) begin
        zflag_r <= rd_oor;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r   <= in_data.cmd;
            nd_r[0] <= in_data.node_a;
            nd_r[1] <= in_data.node_b;
            nd_r[2] <= in_data.node_c;
            nd_r[3] <= in_data.node_d;
            ref_r   <= in_data.region_ref;
            j_r     <= 2'd0;
            scan_r  <= '0;
            fresh_r <= '0;
            new_r   <= '0;
            dup_r   <= '0;
            if (in_data.cmd == umr2d_pkg::CMD_LOAD) begin
              if (pc_r == PC_W'(MAX_POINTS)) begin
                state_r <= S_OVF;
              end else begin
                pc_r <= pc_r + 1'b1;
              end
            end else begin
              state_r <= S_LK_RD;
            end
          end
        end
        S_LK_RD: begin
          if (scan_r < ec_r) begin
            state_r <= S_LK_CMP;
          end else begin
            // Not in the table: new edge, or a repeat within this item.
            key_r[j_r]  <= key_cur;
            new_r[j_r]  <= !dup_hit;
            dup_r[j_r]  <= dup_hit;
            dupk_r[j_r] <= dup_k;
            if (!dup_hit) begin
              fresh_r <= fresh_r + 3'd1;
            end
            scan_r <= '0;
            if (j_r == j_last) begin
              state_r <= S_CHECK;
            end else begin
              j_r <= j_r + 2'd1;
            end
          end
        end
        S_LK_CMP: begin
          if (e_q[KW+PIDX_W-1:PIDX_W] == key_cur) begin
            key_r[j_r] <= key_cur;
            mid_r[j_r] <= e_q[PIDX_W-1:0];
            scan_r     <= '0;
            if (j_r == j_last) begin
              state_r <= S_CHECK;
            end else begin
              j_r     <= j_r + 2'd1;
              state_r <= S_LK_RD;
            end
          end else begin
            scan_r  <= scan_r + 1'b1;
            state_r <= S_LK_RD;
          end
        end
        S_CHECK: begin
          j_r <= 2'd0;
          state_r <= ovf_elem ? S_OVF : S_MP_NEXT;
        end
        S_MP_NEXT: begin
          if (new_r[j_r]) begin
            state_r <= S_MP_RA;
          end else begin
            if (dup_r[j_r]) begin
              mid_r[j_r] <= mid_r[dupk_r[j_r]];
            end
            if (j_r == j_last) begin
              k_r     <= 2'd0;
              cen_i_r <= 2'd0;
              hx_r    <= '0;
              hy_r    <= '0;
              lx_r    <= '0;
              ly_r    <= '0;
              state_r <= (cmd_r == umr2d_pkg::CMD_QUAD) ? S_CEN_RA : S_CHILD;
            end else begin
              j_r <= j_r + 2'd1;
            end
          end
        end
        S_MP_RA: begin
          state_r <= S_MP_RB;
        end
        S_MP_RB: begin
          ax_r    <= cur_x;
          ay_r    <= cur_y;
          state_r <= S_MP_WR;
        end
        S_MP_WR: begin
          if (!ostall) begin
            out_data_r  <= '{kind: umr2d_pkg::KIND_POINT, point_index: NW'(pc_r),
                             out_x: 32'(mx), out_y: 32'(my), default: '0};
            mid_r[j_r]  <= pc_r[PIDX_W-1:0];
            new_r[j_r]  <= 1'b0;
            pc_r        <= pc_r + 1'b1;
            ec_r        <= ec_r + 1'b1;
            state_r     <= S_MP_NEXT;
          end
        end
        S_CEN_RA: begin
          state_r <= S_CEN_ACC;
        end
        S_CEN_ACC: begin
          hx_r <= hx_r + (cur_x >>> 2);
          hy_r <= hy_r + (cur_y >>> 2);
          lx_r <= lx_r + 4'(cur_x[1:0]);
          ly_r <= ly_r + 4'(cur_y[1:0]);
          cen_i_r <= cen_i_r + 2'd1;
          state_r <= (cen_i_r == 2'd3) ? S_CEN_WR : S_CEN_RA;
        end
        S_CEN_WR: begin
          if (!ostall) begin
            out_data_r  <= '{kind: umr2d_pkg::KIND_POINT, point_index: NW'(pc_r),
                             out_x: 32'(cx), out_y: 32'(cy), default: '0};
            cen_r       <= pc_r[PIDX_W-1:0];
            pc_r        <= pc_r + 1'b1;
            state_r     <= S_CHILD;
          end
        end
        S_CHILD: begin
          if (!ostall) begin
            out_data_r  <= child;
            k_r         <= k_r + 2'd1;
            if (child.last) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_OVF: begin
          if (!ostall) begin
            out_data_r  <= '{kind: umr2d_pkg::KIND_OVF, last: 1'b1, default: '0};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The point store and edge table never fill past their depth.
  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_W'(MAX_POINTS)) else $error("point count beyond store depth");

  a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ec_r <= EC_W'(EDGE_SLOTS)) else $error("edge count beyond table depth");

  // Every new edge comes with exactly one new midpoint.
  a_edge_point: assert property (@(posedge clk) disable iff (!rst_n)
    (ec_r != $past(ec_r)) |-> (pc_r == $past(pc_r) + 1'b1))
    else $error("edge inserted without a midpoint");

  // A result is only produced while no earlier result is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_data_r))
    else $error("stalled result overwritten");

endmodule
